[src/lcdw_pkg.sv]
`default_nettype none
package lcdw_pkg;

    localparam int NUM_BITS   = 16;
    localparam int NUM_DIGITS = 5;
    localparam int BCD_W      = 4 * NUM_DIGITS;

    localparam logic [2:0] KIND_INIT   = 3'd0;
    localparam logic [2:0] KIND_CMD    = 3'd1;
    localparam logic [2:0] KIND_CHAR   = 3'd2;
    localparam logic [2:0] KIND_CURSOR = 3'd3;
    localparam logic [2:0] KIND_NUMBER = 3'd4;

    localparam logic [7:0] CMD_FUNC_SET  = 8'b0011_1000;
    localparam logic [7:0] CMD_DISP_ON   = 8'b0000_1100;
    localparam logic [7:0] CMD_CLEAR     = 8'b0000_0001;
    localparam logic [7:0] CMD_ENTRY     = 8'b0000_0110;
    localparam logic [7:0] CMD_LINE0     = 8'h80;
    localparam logic [7:0] CMD_LINE1     = 8'hC0;
    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [5:0] NUM_COLS      = 6'd16;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CMD_FUNC_SET;
            2'd1:    b = CMD_DISP_ON;
            2'd2:    b = CMD_CLEAR;
            default: b = CMD_ENTRY;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

[src/char_lcd_write_sequencer.sv]
`default_nettype none
// command, character and cursor words appear in the cycle after accept
// init: four words, one per cycle when not stalled, the first in the cycle after accept
// number: serial binary-to-bcd loop with one shift per input bit, a capture state, up to 4
// leading-zero digits skipped, then one digit word per cycle when not stalled
// one request at a time: o_stall stays high until the last word is taken
// synchronous active-low reset clears state and the output valid
module char_lcd_write_sequencer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [2:0] i_kind,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_row,
    input  wire logic [4:0] i_column,
    input  wire logic [lcdw_pkg::NUM_BITS-1:0] i_number,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_register_select,
    output logic [7:0]      o_bus_byte,
    output logic            o_last
);
    import lcdw_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_SKIP, S_OUT} t_state;

    t_state           r_state, n_state;
    logic             r_valid, n_valid;
    logic             r_rs, n_rs;
    logic [7:0]       r_byte, n_byte;
    logic             r_last, n_last;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [2:0]       r_left, n_left;
    logic [1:0]       r_idx, n_idx;
    logic             r_digits, n_digits;

    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_start;
    logic             w_done;
    logic [BCD_W-1:0] w_bcd;
    logic [3:0]       w_top;
    logic [7:0]       w_base;

    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_valid && !i_stall;
    assign w_start   = w_in_acc && (i_kind == KIND_NUMBER);
    assign w_top     = r_bcd[BCD_W-1 -: 4];
    assign w_base    = i_row ? CMD_LINE1 : CMD_LINE0;

    lcdw_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (i_number),
        .o_done  (w_done),
        .o_bcd   (w_bcd)
    );

    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_rs     = r_rs;
        n_byte   = r_byte;
        n_last   = r_last;
        n_bcd    = r_bcd;
        n_left   = r_left;
        n_idx    = r_idx;
        n_digits = r_digits;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_kind) inside
                        KIND_INIT: begin
                            n_valid  = 1'b1;
                            n_rs     = RS_CMD;
                            n_byte   = init_byte(2'd0);
                            n_last   = 1'b0;
                            n_idx    = 2'd1;
                            n_digits = 1'b0;
                            n_state  = S_OUT;
                        end
                        KIND_CMD, KIND_CHAR: begin
                            n_valid = 1'b1;
                            n_rs    = (i_kind == KIND_CHAR) ? RS_DATA : RS_CMD;
                            n_byte  = i_byte_value;
                            n_last  = 1'b1;
                            n_state = S_OUT;
                        end
                        KIND_CURSOR: begin
                            n_valid = 1'b1;
                            n_rs    = RS_CMD;
                            // columns past the line end go to line start
                            n_byte  = ({1'b0, i_column} < NUM_COLS)
                                      ? (w_base | {4'd0, i_column[3:0]}) : w_base;
                            n_last  = 1'b1;
                            n_state = S_OUT;
                        end
                        KIND_NUMBER: begin
                            n_digits = 1'b1;
                            n_state  = S_CONV;
                        end
                        default: ;
                    endcase
                end
            end
            S_CONV: begin
                if (w_done) begin
                    n_bcd   = w_bcd;
                    n_left  = 3'(NUM_DIGITS);
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                // drop leading zero digits, keep at least one
                if (w_top == 4'd0 && r_left > 3'd1) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left = r_left - 3'd1;
                end else begin
                    n_valid = 1'b1;
                    n_rs    = RS_DATA;
                    n_byte  = ASCII_ZERO | {4'd0, w_top};
                    n_last  = (r_left == 3'd1);
                    n_bcd   = {r_bcd[BCD_W-5:0], 4'd0};
                    n_left  = r_left - 3'd1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_acc) begin
                    if (r_last) begin
                        n_valid = 1'b0;
                        n_state = S_IDLE;
                    end else if (r_digits) begin
                        n_byte = ASCII_ZERO | {4'd0, w_top};
                        n_last = (r_left == 3'd1);
                        n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                        n_left = r_left - 3'd1;
                    end else begin
                        n_byte = init_byte(r_idx);
                        n_last = (r_idx == 2'd3);
                        n_idx  = r_idx + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_digits <= 1'b0;
            r_left   <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_digits <= n_digits;
            r_left   <= n_left;
            r_idx    <= n_idx;
        end
        r_rs   <= n_rs;
        r_byte <= n_byte;
        r_last <= n_last;
        r_bcd  <= n_bcd;
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_register_select = r_rs;
    assign o_bus_byte        = r_byte;
    assign o_last            = r_last;

    a_valid_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == S_OUT) && o_stall)
        else $error("output valid outside output state");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_stall && !r_last) |=> r_valid)
        else $error("write run broke before last word");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_CONV))
        else $error("conversion finished outside conversion state");

endmodule
`default_nettype wire

[src/lcdw_bcd.sv]
`default_nettype none
module lcdw_bcd (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [lcdw_pkg::NUM_BITS-1:0] i_value,
    output logic                            o_done,
    output logic [lcdw_pkg::BCD_W-1:0]      o_bcd
);
    import lcdw_pkg::*;

    localparam int CNT_W = $clog2(NUM_BITS);

    logic [NUM_BITS-1:0] r_bin;
    logic [BCD_W-1:0]    r_bcd;
    logic [BCD_W-1:0]    w_adj;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_busy;
    logic                r_done;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        logic [3:0] dig;
        w_adj = r_bcd;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            dig = r_bcd[4*d +: 4];
            w_adj[4*d +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_BITS - 1);
                r_bin  <= i_value;
                r_bcd  <= '0;
            end else if (r_busy) begin
                r_bcd <= {w_adj[BCD_W-2:0], r_bin[NUM_BITS-1]};
                r_bin <= {r_bin[NUM_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdw_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_REQS  = 400;
    localparam int MAX_REPORTED = 10;
    localparam int HOLD_CYCLES  = 250;

    typedef struct {
        logic [2:0]          kind;
        logic [7:0]          byte_value;
        logic                row;
        logic [4:0]          column;
        logic [NUM_BITS-1:0] number;
        int                  gap;
        bit                  drain;
    } t_lcd_req;

    typedef struct {
        logic       rs;
        logic [7:0] bus_byte;
        logic       last;
    } t_lcd_write;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [2:0]          i_kind = '0;
    logic [7:0]          i_byte_value = '0;
    logic                i_row = 1'b0;
    logic [4:0]          i_column = '0;
    logic [NUM_BITS-1:0] i_number = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_register_select;
    logic [7:0]          o_bus_byte;
    logic                o_last;

    t_lcd_req   pending_reqs[$];
    t_lcd_write expected_writes[$];

    int  cycle_cnt = 0;
    int  reqs_accepted = 0;
    int  words_checked = 0;
    int  mismatches = 0;
    int  kind_count[8];
    bit  in_taken = 1'b0;
    bit  out_taken = 1'b0;
    int  hold_left = 0;
    int  holds_done = 0;

    char_lcd_write_sequencer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_byte_value     (i_byte_value),
        .i_row            (i_row),
        .i_column         (i_column),
        .i_number         (i_number),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_register_select(o_register_select),
        .o_bus_byte       (o_bus_byte),
        .o_last           (o_last)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // bus writes that one request turns into, queued in order
    function automatic void predict_bus_writes(t_lcd_req r);
        logic [7:0]  init_cmds[4];
        int unsigned place[5];
        int unsigned rest;
        int unsigned digit;
        bit          started;
        logic [7:0]  addr;
        t_lcd_write  run[$];
        t_lcd_write  w;
        init_cmds = '{CMD_FUNC_SET, CMD_DISP_ON, CMD_CLEAR, CMD_ENTRY};
        place = '{10000, 1000, 100, 10, 1};
        w.last = 1'b0;
        case (r.kind)
            KIND_INIT: begin
                for (int i = 0; i < 4; i++) begin
                    w.rs = RS_CMD;
                    w.bus_byte = init_cmds[i];
                    run.push_back(w);
                end
            end
            KIND_CMD: begin
                w.rs = RS_CMD;
                w.bus_byte = r.byte_value;
                run.push_back(w);
            end
            KIND_CHAR: begin
                w.rs = RS_DATA;
                w.bus_byte = r.byte_value;
                run.push_back(w);
            end
            KIND_CURSOR: begin
                addr = r.row ? CMD_LINE1 : CMD_LINE0;
                // columns past the line width park the cursor at line start
                if ({1'b0, r.column} < NUM_COLS) addr = addr + {3'd0, r.column};
                w.rs = RS_CMD;
                w.bus_byte = addr;
                run.push_back(w);
            end
            KIND_NUMBER: begin
                rest = 32'(r.number);
                started = 1'b0;
                // zero still prints its last digit
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    digit = rest / place[i];
                    rest = rest % place[i];
                    if (digit != 0 || i == NUM_DIGITS - 1) started = 1'b1;
                    if (started) begin
                        w.rs = RS_DATA;
                        w.bus_byte = ASCII_ZERO + digit[7:0];
                        run.push_back(w);
                    end
                end
            end
            default: ;
        endcase
        if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        foreach (run[i]) expected_writes.push_back(run[i]);
    endfunction

    function automatic t_lcd_req make_req(logic [2:0] kind, logic [7:0] bv, logic row,
                                          logic [4:0] col, logic [NUM_BITS-1:0] num,
                                          int gap, bit drain);
        t_lcd_req r;
        r.kind = kind;
        r.byte_value = bv;
        r.row = row;
        r.column = col;
        r.number = num;
        r.gap = gap;
        r.drain = drain;
        return r;
    endfunction

    function automatic logic [NUM_BITS-1:0] rand_number();
        int unsigned n;
        case ($urandom_range(0, 5))
            0:       n = $urandom_range(0, 9);
            1:       n = $urandom_range(10, 99);
            2:       n = $urandom_range(100, 999);
            3:       n = $urandom_range(1000, 9999);
            default: n = $urandom_range(10000, 65535);
        endcase
        return n[NUM_BITS-1:0];
    endfunction

    task automatic fill_requests();
        int          made;
        int          idx;
        int unsigned pick;
        logic [2:0]  kind;
        int          gap;
        made = 0;
        idx = 0;
        // directed: extremes, every request kind, edge columns and numbers
        pending_reqs.push_back(make_req(KIND_INIT, 8'h00, 1'b0, 5'd0, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CMD, 8'h00, 1'b0, 5'd0, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CMD, 8'hFF, 1'b1, 5'd31, 16'hFFFF, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CHAR, 8'h00, 1'b0, 5'd0, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CHAR, 8'hFF, 1'b0, 5'd0, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CHAR, 8'hA5, 1'b1, 5'd10, 16'h5A5A, 1, 1'b0));
        pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 1'b0, 5'd0, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 1'b0, 5'd15, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 1'b0, 5'd16, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CURSOR, 8'hFF, 1'b0, 5'd31, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 1'b1, 5'd0, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 1'b1, 5'd15, 16'd0, 2, 1'b0));
        pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 1'b1, 5'd16, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_CURSOR, 8'h00, 1'b1, 5'd31, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 1'b0, 5'd0, 16'd0, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 1'b0, 5'd0, 16'd1, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 1'b0, 5'd0, 16'd9, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 1'b0, 5'd0, 16'd10, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 1'b0, 5'd0, 16'd100, 3, 1'b0));
        pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 1'b0, 5'd0, 16'd9999, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_NUMBER, 8'h00, 1'b0, 5'd0, 16'd10000, 0, 1'b0));
        pending_reqs.push_back(make_req(KIND_NUMBER, 8'hFF, 1'b1, 5'd31, 16'd65535, 0, 1'b0));
        // unused kinds must produce nothing
        pending_reqs.push_back(make_req(3'd5, 8'h3C, 1'b1, 5'd7, 16'd1234, 0, 1'b0));
        pending_reqs.push_back(make_req(3'd6, 8'hFF, 1'b0, 5'd31, 16'hFFFF, 0, 1'b0));
        pending_reqs.push_back(make_req(3'd7, 8'h00, 1'b1, 5'd0, 16'd0, 0, 1'b1));

        while (made < RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)       kind = KIND_INIT;
            else if (pick < 28) kind = KIND_CMD;
            else if (pick < 50) kind = KIND_CHAR;
            else if (pick < 70) kind = KIND_CURSOR;
            else if (pick < 95) kind = KIND_NUMBER;
            else                kind = 3'($urandom_range(5, 7));
            // every fourth stretch of 25 requests goes back to back
            gap = ((idx / 25) % 4 == 3) ? 0 : $urandom_range(0, 10);
            pending_reqs.push_back(make_req(kind, 8'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1)),
                                            5'($urandom_range(0, 31)), rand_number(),
                                            gap, (idx % 90) == 45));
            if (kind <= KIND_NUMBER) made++;
            idx++;
        end
    endtask

    // request side
    always @(negedge i_clk) begin : drive_requests
        logic     next_valid;
        t_lcd_req cur;
        int       gap_left;
        bit       gap_armed;
        next_valid = i_valid;
        if (i_rst_n) begin
            if (i_valid && in_taken) next_valid = 1'b0;
            if (!next_valid && pending_reqs.size() > 0) begin
                if (!gap_armed) begin
                    gap_left = pending_reqs[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!(pending_reqs[0].drain && expected_writes.size() != 0)) begin
                    cur = pending_reqs.pop_front();
                    gap_armed = 1'b0;
                    next_valid = 1'b1;
                    i_kind <= cur.kind;
                    i_byte_value <= cur.byte_value;
                    i_row <= cur.row;
                    i_column <= cur.column;
                    i_number <= cur.number;
                end
            end
        end
        i_valid <= next_valid;
    end

    // long output hold so the block backs up while requests keep coming
    always @(negedge i_clk) begin : long_hold
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && reqs_accepted >= (holds_done + 1) * 140) begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // bus side
    always @(negedge i_clk) begin : drive_sink
        int rx_wait;
        bit rx_armed;
        if (out_taken || !rx_armed) begin
            rx_wait = ((cycle_cnt / 1500) % 5 == 2) ? 0 : $urandom_range(0, 10);
            rx_armed = 1'b1;
        end
        i_stall <= (rx_wait > 0) || (hold_left > 0);
        if (rx_wait > 0) rx_wait--;
    end

    always @(posedge i_clk) begin : watch_ports
        bit         took_req;
        bit         took_word;
        t_lcd_req   r;
        t_lcd_write want;
        took_req = i_rst_n && i_valid && !o_stall;
        took_word = i_rst_n && o_valid && !i_stall;
        cycle_cnt <= cycle_cnt + 1;
        // check before predicting so a new request never feeds this edge's word
        if (took_word) begin
            words_checked++;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("unexpected word at cycle %0d: rs=%0b byte=%02h last=%0b",
                             cycle_cnt, o_register_select, o_bus_byte, o_last);
            end else begin
                want = expected_writes.pop_front();
                if (o_register_select !== want.rs || o_bus_byte !== want.bus_byte ||
                    o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("mismatch at cycle %0d: expected rs=%0b byte=%02h last=%0b, %s",
                                 cycle_cnt, want.rs, want.bus_byte, want.last,
                                 $sformatf("got rs=%0b byte=%02h last=%0b",
                                           o_register_select, o_bus_byte, o_last));
                end
            end
        end
        if (took_req) begin
            r = make_req(i_kind, i_byte_value, i_row, i_column, i_number, 0, 1'b0);
            predict_bus_writes(r);
            kind_count[i_kind]++;
            reqs_accepted <= reqs_accepted + 1;
        end
        in_taken <= took_req;
        out_taken <= took_word;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        foreach (kind_count[i]) kind_count[i] = 0;
        fill_requests();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || i_valid || expected_writes.size() != 0)
            @(posedge i_clk);
        // number requests convert before they write, so watch a while for stray words
        repeat (40) @(posedge i_clk);
        if (expected_writes.size() != 0) begin
            mismatches += expected_writes.size();
            $display("%0d expected words never arrived", expected_writes.size());
        end
        $display("requests: init %0d, command %0d, char %0d, cursor %0d, number %0d, unused %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4],
                 kind_count[5] + kind_count[6] + kind_count[7]);
        $display("%0d bus words checked in %0d cycles, %0d long output holds, %0d mismatches",
                 words_checked, cycle_cnt, holds_done, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
